[rtl/core/rgp_pkg.sv]
`timescale 1ns / 1ps

package rgp_pkg;

    localparam int NUM_TERMS      = 31;
    localparam int NUM_SETS       = 3;
    localparam int COEF_WIDTH_DEF = 64;
    localparam int MONO_W         = 64;
    localparam int VAR_W          = 29;
    localparam int ACC_W          = 128;
    localparam int OUT_W          = 48;
    localparam int LIMB_W         = 32;
    localparam int MUL_LAT        = 3;
    localparam int TREE_LVL       = $clog2(NUM_TERMS);
    localparam int PRE_LAT        = 3;
    localparam int LAT            = PRE_LAT + 4 * MUL_LAT + TREE_LVL + 2;

    localparam int Q_SHIFT        = 16;
    localparam int COEF_SHIFT     = 40;

    localparam int LVL1_LO        = 4;
    localparam int LVL1_HI        = 9;
    localparam int LVL2_LO        = 10;
    localparam int LVL2_HI        = 18;
    localparam int LVL3_LO        = 19;
    localparam int LVL3_HI        = 30;

    localparam int TERM_ONE       = 0;
    localparam int TERM_Y         = 1;
    localparam int TERM_X         = 2;
    localparam int TERM_T         = 3;

    localparam logic signed [VAR_W-1:0] LAT_OFS    = VAR_W'(15 * 4096);
    localparam logic signed [VAR_W-1:0] LON_OFS    = VAR_W'(55 * 4096);
    localparam logic signed [12:0]      EPOCH_YEAR = 13'sd1990;
    localparam logic [12:0]             MONTH_MUL  = 13'd316;
    localparam logic [12:0]             DAY_MUL    = 13'd10;
    localparam logic [27:0]             DATE_BIAS  = 28'd912;
    localparam logic [28:0]             RECIP_1825 = 29'd301236063;
    localparam int                      RECIP_SHIFT = 39;
    localparam int                      PROD_N_W   = 57;

    localparam logic signed [MONO_W-1:0] MONO_ONE = MONO_W'(65536);
    localparam logic [ACC_W-1:0] ACC_RND = ACC_W'(1) << (COEF_SHIFT - 1);
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    localparam longint NANO_DIV5  = 1953125;
    localparam longint NANO_DIV10 = 3906250;

    localparam int SRC_TERM [NUM_TERMS] = '{
        0, 0, 0, 0,
        2, 2, 2, 1, 1, 3,
        4, 4, 4, 5, 5, 6, 7, 7, 8,
        10, 10, 10, 11, 11, 12, 13, 13, 16, 14, 16, 17
    };

    localparam int VAR_TERM [NUM_TERMS] = '{
        0, 0, 0, 0,
        2, 1, 3, 1, 3, 3,
        2, 1, 3, 1, 3, 3, 1, 3, 3,
        2, 1, 3, 1, 3, 3, 1, 3, 3, 3, 1, 3
    };

    localparam longint COEF_NANO [NUM_SETS * NUM_TERMS] = '{
        -64'sd14021375662, -64'sd168692826, -64'sd728121347, -64'sd152403506,
        64'sd9284154, 64'sd10645054, 64'sd3762631, 64'sd6069034, 64'sd997887,
        64'sd660849, 64'sd228488, 64'sd147266, 64'sd138951, 64'sd102790,
        64'sd77382, 64'sd33104, -64'sd80797, 64'sd81799, 64'sd23869,
        -64'sd3334, -64'sd1624, -64'sd2092, 64'sd783, -64'sd687, -64'sd467,
        -64'sd3224, 64'sd1136, -64'sd597, -64'sd384, -64'sd734, 64'sd313,
        64'sd24227701493629, 64'sd179249482444, -64'sd35691312861,
        -64'sd40650445499, 64'sd3389231202, -64'sd2877812250,
        64'sd1344553781, 64'sd7868317612, -64'sd1264195795, 64'sd139587984,
        64'sd12235070, -64'sd81386418, 64'sd17733176, -64'sd129043199,
        64'sd9808419, 64'sd10965888, -64'sd11413932, -64'sd50601698,
        64'sd6210802, -64'sd669293, 64'sd2824651, -64'sd611097,
        -64'sd1058025, 64'sd2319666, -64'sd389784, 64'sd821961, -64'sd72882,
        64'sd208254, 64'sd650523, 64'sd52505, 64'sd318015,
        -64'sd9931508298, 64'sd1664769881, -64'sd744295714, -64'sd255241128,
        -64'sd19318551, -64'sd11764453, -64'sd9579100, 64'sd11203395,
        -64'sd2852682, -64'sd1215262, 64'sd231976, -64'sd118681, 64'sd138764,
        64'sd350319, -64'sd92585, 64'sd41703, -64'sd325057, 64'sd109148,
        -64'sd24326, 64'sd5284, -64'sd293, 64'sd4412, 64'sd8477, 64'sd253,
        64'sd1704, 64'sd7985, 64'sd4631, 64'sd1676, 64'sd427, -64'sd4156,
        64'sd1236
    };

    function automatic logic [63:0] coef_q40(input int idx);
        longint     n;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] val;
        n   = COEF_NANO[idx];
        mag = (n < 0) ? 64'(-n) : 64'(n);
        q   = mag / 64'(NANO_DIV5);
        r   = mag % 64'(NANO_DIV5);
        val = (q << 31) + ((r << 32) + 64'(NANO_DIV5)) / 64'(NANO_DIV10);
        if (n < 0)
        begin
            val = 64'd0 - val;
        end
        return val;
    endfunction

endpackage

[rtl/core/rgp_mul.sv]
`timescale 1ns / 1ps

module rgp_mul
    import rgp_pkg::*;
#(
    parameter int WA  = 64,
    parameter int WB  = 64,
    parameter int RND = 0
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [WA-1:0]     a,
    input  logic signed [WB-1:0]     b,
    output logic signed [WA+WB-1:0]  p
);

    localparam int WP = WA + WB;
    localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int AE = NA * LIMB_W;
    localparam int BE = NB * LIMB_W;
    localparam logic signed [WP-1:0] RC = (RND > 0) ? (WP'(1) << (RND - 1)) : '0;

    logic signed [AE-1:0]       a_ext;
    logic signed [BE-1:0]       b_ext;
    logic signed [LIMB_W:0]     a_limb [NA];
    logic signed [LIMB_W:0]     b_limb [NB];
    logic signed [2*LIMB_W+1:0] pp_reg [NA][NB];
    logic signed [WP-1:0]       row_next [NA];
    logic signed [WP-1:0]       row_reg [NA];
    logic signed [WP-1:0]       p_next;
    logic signed [WP-1:0]       p_reg;

    assign a_ext = AE'(a);
    assign b_ext = BE'(b);

    for (genvar i = 0; i < NA; i++)
    begin : g_alimb
        assign a_limb[i] = {(i == NA - 1) ? a_ext[LIMB_W*i+LIMB_W-1] : 1'b0,
                            a_ext[LIMB_W*i +: LIMB_W]};
    end

    for (genvar j = 0; j < NB; j++)
    begin : g_blimb
        assign b_limb[j] = {(j == NB - 1) ? b_ext[LIMB_W*j+LIMB_W-1] : 1'b0,
                            b_ext[LIMB_W*j +: LIMB_W]};
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_row
        for (genvar j = 0; j < NB; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[i][j] <= a_limb[i] * b_limb[j];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (WP'(pp_reg[i][j]) <<< (LIMB_W * j));
            end
        end
    end

    always_comb
    begin
        p_next = RC;
        for (int i = 0; i < NA; i++)
        begin
            p_next = p_next + (row_reg[i] <<< (LIMB_W * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/core/rgp_level.sv]
`timescale 1ns / 1ps

module rgp_level
    import rgp_pkg::*;
#(
    parameter int LO = LVL1_LO,
    parameter int HI = LVL1_HI
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MONO_W-1:0] mono [NUM_TERMS],
    output logic signed [MONO_W-1:0] mono_out [NUM_TERMS]
);

    for (genvar k = 0; k < NUM_TERMS; k++)
    begin : g_term
        if (k < LO)
        begin : g_hold
            logic signed [MONO_W-1:0] d_reg [MUL_LAT];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[0] <= mono[k];
                    for (int n = 1; n < MUL_LAT; n++)
                    begin
                        d_reg[n] <= d_reg[n-1];
                    end
                end
            end

            assign mono_out[k] = d_reg[MUL_LAT-1];
        end
        else if (k <= HI)
        begin : g_mul
            logic signed [MONO_W+VAR_W-1:0] p;

            rgp_mul #(
                .WA  (MONO_W),
                .WB  (VAR_W),
                .RND (Q_SHIFT)
            ) u_mul (
                .clk (clk),
                .en  (en),
                .a   (mono[SRC_TERM[k]]),
                .b   ($signed(mono[VAR_TERM[k]][VAR_W-1:0])),
                .p   (p)
            );

            assign mono_out[k] = p[Q_SHIFT+MONO_W-1:Q_SHIFT];
        end
        else
        begin : g_zero
            assign mono_out[k] = '0;
        end
    end

endmodule

[rtl/core/rgp_terms.sv]
`timescale 1ns / 1ps

module rgp_terms
    import rgp_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MONO_W-1:0] mono [NUM_TERMS],
    output logic signed [ACC_W-1:0]  prod [NUM_SETS][NUM_TERMS]
);

    for (genvar s = 0; s < NUM_SETS; s++)
    begin : g_set
        for (genvar k = 0; k < NUM_TERMS; k++)
        begin : g_term
            localparam logic [63:0] CQ = coef_q40(s * NUM_TERMS + k);

            logic signed [COEF_WIDTH-1:0]        coef;
            logic signed [COEF_WIDTH+MONO_W-1:0] p;

            assign coef = $signed(CQ[COEF_WIDTH-1:0]);

            rgp_mul #(
                .WA  (COEF_WIDTH),
                .WB  (MONO_W),
                .RND (0)
            ) u_mul (
                .clk (clk),
                .en  (en),
                .a   (coef),
                .b   (mono[k]),
                .p   (p)
            );

            assign prod[s][k] = ACC_W'(p);
        end
    end

endmodule

[rtl/core/rgp_sum.sv]
`timescale 1ns / 1ps

module rgp_sum
    import rgp_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ACC_W-1:0] leaf_in [NUM_TERMS],
    output logic signed [ACC_W-1:0] total
);

    localparam int LEAVES = 1 << TREE_LVL;

    logic signed [ACC_W-1:0] leaf [LEAVES];
    logic signed [ACC_W-1:0] node_reg [1:LEAVES-1];

    for (genvar k = 0; k < LEAVES; k++)
    begin : g_leaf
        if (k < NUM_TERMS)
        begin : g_used
            assign leaf[k] = leaf_in[k];
        end
        else
        begin : g_pad
            assign leaf[k] = '0;
        end
    end

    for (genvar i = 1; i < LEAVES; i++)
    begin : g_node
        logic signed [ACC_W-1:0] lhs;
        logic signed [ACC_W-1:0] rhs;

        if (2 * i >= LEAVES)
        begin : g_bottom
            assign lhs = leaf[2*i-LEAVES];
            assign rhs = leaf[2*i+1-LEAVES];
        end
        else
        begin : g_inner
            assign lhs = node_reg[2*i];
            assign rhs = node_reg[2*i+1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                node_reg[i] <= lhs + rhs;
            end
        end
    end

    assign total = node_reg[1];

endmodule

[rtl/core/regional_geomagnetic_polynomial.sv]
`timescale 1ns / 1ps
// Stages: input, monomial levels, products, adder tree, rounding, output.
// Throughput: one transaction per cycle; every stage advances together and
// holds only while a finished result waits on out_stall.
// Reset: rst_n clears the valid pipeline at once; coefficients are constants,
// so no clearing pass is needed.

module regional_geomagnetic_polynomial
    import rgp_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [19:0]      latitude,
    input  logic signed [20:0]      longitude_deg,
    input  logic [4:0]              day_of_month,
    input  logic [3:0]              month_number,
    input  logic [11:0]             year_number,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] declination_out,
    output logic signed [OUT_W-1:0] intensity_out,
    output logic signed [OUT_W-1:0] inclination_out,
    output logic                    saturated_flag
);

    logic                     en;
    logic [LAT-1:0]           vld_reg;

    logic signed [VAR_W-1:0]  x_next;
    logic signed [VAR_W-1:0]  y_next;
    logic [12:0]              s_next;
    logic [27:0]              n_next;
    logic signed [12:0]       yr_next;
    logic signed [VAR_W-1:0]  xa_reg;
    logic signed [VAR_W-1:0]  ya_reg;
    logic [27:0]              na_reg;
    logic signed [12:0]       yra_reg;

    logic signed [VAR_W-1:0]  xb_reg;
    logic signed [VAR_W-1:0]  yb_reg;
    logic signed [12:0]       yrb_reg;
    logic [PROD_N_W-1:0]      nm_reg;

    logic signed [VAR_W-1:0]  t_next;
    logic signed [VAR_W-1:0]  xc_reg;
    logic signed [VAR_W-1:0]  yc_reg;
    logic signed [VAR_W-1:0]  tc_reg;

    logic signed [MONO_W-1:0] mono0 [NUM_TERMS];
    logic signed [MONO_W-1:0] mono1 [NUM_TERMS];
    logic signed [MONO_W-1:0] mono2 [NUM_TERMS];
    logic signed [MONO_W-1:0] mono3 [NUM_TERMS];
    logic signed [ACC_W-1:0]  prod [NUM_SETS][NUM_TERMS];
    logic signed [ACC_W-1:0]  acc [NUM_SETS];
    logic signed [ACC_W-1:0]  rnd_reg [NUM_SETS];

    logic signed [OUT_W-1:0]  res_next [NUM_SETS];
    logic [NUM_SETS-1:0]      sat_next;
    logic signed [OUT_W-1:0]  res_reg [NUM_SETS];
    logic                     sat_reg;

    // advance unless a result is held by the sink
    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        x_next  = (VAR_W'(longitude_deg) + LON_OFS) <<< 4;
        y_next  = (VAR_W'(latitude) + LAT_OFS) <<< 4;
        s_next  = 13'(month_number) * MONTH_MUL + 13'(day_of_month) * DAY_MUL;
        n_next  = {s_next, 15'd0} + DATE_BIAS;
        yr_next = $signed({1'b0, year_number}) - EPOCH_YEAR;
    end

    always_comb
    begin
        t_next = (VAR_W'(yrb_reg) <<< Q_SHIFT)
               + $signed(VAR_W'(nm_reg[PROD_N_W-1:RECIP_SHIFT]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg  <= x_next;
            ya_reg  <= y_next;
            na_reg  <= n_next;
            yra_reg <= yr_next;
            xb_reg  <= xa_reg;
            yb_reg  <= ya_reg;
            yrb_reg <= yra_reg;
            nm_reg  <= PROD_N_W'(na_reg) * PROD_N_W'(RECIP_1825);
            xc_reg  <= xb_reg;
            yc_reg  <= yb_reg;
            tc_reg  <= t_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            mono0[k] = '0;
        end
        mono0[TERM_ONE] = MONO_ONE;
        mono0[TERM_Y]   = MONO_W'(yc_reg);
        mono0[TERM_X]   = MONO_W'(xc_reg);
        mono0[TERM_T]   = MONO_W'(tc_reg);
    end

    rgp_level #(.LO(LVL1_LO), .HI(LVL1_HI)) u_lvl1 (
        .clk      (clk),
        .en       (en),
        .mono     (mono0),
        .mono_out (mono1)
    );

    rgp_level #(.LO(LVL2_LO), .HI(LVL2_HI)) u_lvl2 (
        .clk      (clk),
        .en       (en),
        .mono     (mono1),
        .mono_out (mono2)
    );

    rgp_level #(.LO(LVL3_LO), .HI(LVL3_HI)) u_lvl3 (
        .clk      (clk),
        .en       (en),
        .mono     (mono2),
        .mono_out (mono3)
    );

    rgp_terms #(.COEF_WIDTH(COEF_WIDTH)) u_terms (
        .clk  (clk),
        .en   (en),
        .mono (mono3),
        .prod (prod)
    );

    for (genvar s = 0; s < NUM_SETS; s++)
    begin : g_set
        rgp_sum u_sum (
            .clk     (clk),
            .en      (en),
            .leaf_in (prod[s]),
            .total   (acc[s])
        );
    end

    always_comb
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            sat_next[s] = !((&rnd_reg[s][ACC_W-1:COEF_SHIFT+OUT_W-1])
                         || !(|rnd_reg[s][ACC_W-1:COEF_SHIFT+OUT_W-1]));
            if (!sat_next[s])
            begin
                res_next[s] = rnd_reg[s][COEF_SHIFT+OUT_W-1:COEF_SHIFT];
            end
            else if (rnd_reg[s][ACC_W-1])
            begin
                res_next[s] = OUT_MIN;
            end
            else
            begin
                res_next[s] = OUT_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                rnd_reg[s] <= acc[s] + $signed(ACC_RND);
                res_reg[s] <= res_next[s];
            end
            sat_reg <= |sat_next;
        end
    end

    assign declination_out = res_reg[0];
    assign intensity_out   = res_reg[1];
    assign inclination_out = res_reg[2];
    assign saturated_flag  = sat_reg;

endmodule

[rtl/core/rgp_check.sv]
`timescale 1ns / 1ps

module rgp_check
    import rgp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] declination_out,
    input logic signed [OUT_W-1:0] intensity_out,
    input logic signed [OUT_W-1:0] inclination_out,
    input logic                    saturated_flag
);

    // input side stalls only behind a held result
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not match held output");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(declination_out)
            && $stable(intensity_out) && $stable(inclination_out)
            && $stable(saturated_flag))
        else $error("stalled transaction changed");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated_flag |->
            declination_out == OUT_MAX || declination_out == OUT_MIN
            || intensity_out == OUT_MAX || intensity_out == OUT_MIN
            || inclination_out == OUT_MAX || inclination_out == OUT_MIN)
        else $error("saturation flag without a clipped output");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind regional_geomagnetic_polynomial rgp_check u_rgp_check (.*);
